FILE: rtl/line_following_heading_controller_macros.svh
// assertion macros shared by the checker files
`ifndef LINE_FOLLOWING_HEADING_CONTROLLER_MACROS_SVH
`define LINE_FOLLOWING_HEADING_CONTROLLER_MACROS_SVH

// condition holds in the same cycle
`define LFHC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define LFHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lfhc_pkg.sv
// shared types, constants and the angle wrap function of the heading controller
package lfhc_pkg;

    localparam int ANGLE_FRAC_BITS = 13;

    localparam longint PI32       = 64'sd13493037705;
    localparam longint SHIFT_UNIT = longint'(1) << (32 - ANGLE_FRAC_BITS);
    localparam int PI_Q  = int'((PI32 + SHIFT_UNIT / 2) / SHIFT_UNIT);
    localparam int C1_Q  = int'((PI32 + 3 * SHIFT_UNIT) / (6 * SHIFT_UNIT));
    localparam int QTR_Q = int'((PI32 + 2 * SHIFT_UNIT) / (4 * SHIFT_UNIT));

    // internal angle width, holds target minus raw yaw
    localparam int ANG_W = (ANGLE_FRAC_BITS + 4 > 17) ? ANGLE_FRAC_BITS + 4 : 17;
    localparam int WRAP_STEPS = (32768 + PI_Q) / (2 * PI_Q) + 1;

    localparam logic signed [ANG_W-1:0] PI_A     = ANG_W'(PI_Q);
    localparam logic signed [ANG_W-1:0] NEG_PI_A = -ANG_W'(PI_Q);
    localparam logic signed [ANG_W-1:0] TWO_PI_A = ANG_W'(2 * PI_Q);
    localparam logic signed [ANG_W-1:0] QTR_A    = ANG_W'(QTR_Q);
    localparam logic signed [ANG_W-1:0] C1_A     = ANG_W'(C1_Q);

    // lateral offset arithmetic, sine and cosine in Q1.14
    localparam int DIFF_W     = 25;
    localparam int OFF_PROD_W = 41;
    localparam int D_W        = 42;
    localparam int OFFSET_LIMIT = 250 * 16384;
    localparam logic signed [D_W-1:0] OFF_HI = D_W'(OFFSET_LIMIT);
    localparam logic signed [D_W-1:0] OFF_LO = -D_W'(OFFSET_LIMIT);

    // speed scaling: round_half_up(v * x / C1) = floor((2 v x + C1) / (2 C1))
    localparam int C1_W    = $clog2(C1_Q + 1);
    localparam int N_W     = 13 + C1_W;
    localparam int DIV_Q   = 2 * C1_Q;
    localparam int RECIP_K = N_W + 2;
    localparam int RECIP_M = int'((longint'(1) << RECIP_K) / DIV_Q);
    localparam int Q_W     = 13;
    localparam int PROD_W  = RECIP_K + Q_W;

    typedef enum logic [2:0] {
        REG_GOAL_SET     = 3'd0,
        REG_GOAL_X       = 3'd1,
        REG_GOAL_Y       = 3'd2,
        REG_GOAL_HEADING = 3'd3,
        REG_GOAL_SINE    = 3'd4,
        REG_GOAL_COSINE  = 3'd5,
        REG_MAX_LINEAR   = 3'd6,
        REG_MAX_ANGULAR  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic               goal_set;
        logic signed [23:0] goal_x;
        logic signed [23:0] goal_y;
        logic signed [15:0] goal_heading;
        logic signed [15:0] goal_sine;
        logic signed [15:0] goal_cosine;
        logic        [9:0]  max_linear;
        logic        [11:0] max_angular;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        goal_set:     1'b0,
        goal_x:       24'sd0,
        goal_y:       24'sd0,
        goal_heading: 16'sd0,
        goal_sine:    16'sd0,
        goal_cosine:  16'sd16384,
        max_linear:   10'd300,
        max_angular:  12'd1000
    };

    typedef struct packed {
        logic               no_goal;
        logic               hi;
        logic               lo;
        logic signed [15:0] yaw;
    } offset_t;

    typedef struct packed {
        logic                    no_goal;
        logic                    sat;
        logic                    neg;
        logic signed [ANG_W-1:0] err;
        logic [C1_W-1:0]         mag;
    } err_t;

    function automatic logic signed [ANG_W-1:0] wrap_angle(
        input logic signed [ANG_W-1:0] v
    );
        logic signed [ANG_W-1:0] r;
        r = v;
        for (int i = 0; i < WRAP_STEPS; i++)
        begin
            if (r > PI_A)
            begin
                r = r - TWO_PI_A;
            end
            else if (r < NEG_PI_A)
            begin
                r = r + TWO_PI_A;
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/line_following_heading_controller.sv
// top level of the line following heading controller
// usage:
//   configuration: cfg_valid/cfg_ready write port, cfg_index selects the register
//   (goal_set, goal_x, goal_y, goal_heading, goal_sine, goal_cosine, max_linear,
//   max_angular), cfg_data carries the value; cfg_ready is always high. write
//   only while no item is in flight.
//   input: one odometry item (pos_x, pos_y, yaw) taken when in_valid && !in_stall
//   output: one command item (linear_speed, angular_speed, heading_error, no_goal)
//   taken when out_valid && !out_stall
//   pipeline: seven register stages (position difference, offset products,
//   compare, heading error, numerators, reciprocal multiply, remainder correction)
//   throughput: one item per cycle while not stalled; each stage has its own
//   valid bit, so input keeps flowing while a result waits until the pipeline is full
//   stall: a stalled result holds; in_stall rises only once every stage is full
//   reset: all stages empty, registers at their defaults with no goal set, so
//   every result reports no_goal with zero speeds
module line_following_heading_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [15:0] yaw,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [9:0]         linear_speed,
    output logic signed [12:0] angular_speed,
    output logic signed [15:0] heading_error,
    output logic               no_goal
);

    lfhc_pkg::cfg_t    cfg;
    lfhc_pkg::offset_t off;
    lfhc_pkg::err_t    herr;

    logic off_valid, off_stall;
    logic err_valid, err_stall;

    lfhc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfhc_offset u_offset (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .yaw       (yaw),
        .out_valid (off_valid),
        .out_stall (off_stall),
        .res       (off)
    );

    lfhc_heading u_heading (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (off_valid),
        .in_stall  (off_stall),
        .src       (off),
        .out_valid (err_valid),
        .out_stall (err_stall),
        .res       (herr)
    );

    lfhc_speed u_speed (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (err_valid),
        .in_stall      (err_stall),
        .src           (herr),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .linear_speed  (linear_speed),
        .angular_speed (angular_speed),
        .heading_error (heading_error),
        .no_goal       (no_goal)
    );

endmodule

FILE: rtl/lfhc_cfg_regs.sv
// configuration register file of the heading controller
module lfhc_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [23:0]     cfg_data,
    output lfhc_pkg::cfg_t  cfg
);

    lfhc_pkg::cfg_t cfg_reg;
    lfhc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (lfhc_pkg::reg_idx_t'(cfg_index))
                lfhc_pkg::REG_GOAL_SET:     cfg_next.goal_set     = cfg_data[0];
                lfhc_pkg::REG_GOAL_X:       cfg_next.goal_x       = cfg_data;
                lfhc_pkg::REG_GOAL_Y:       cfg_next.goal_y       = cfg_data;
                lfhc_pkg::REG_GOAL_HEADING: cfg_next.goal_heading = cfg_data[15:0];
                lfhc_pkg::REG_GOAL_SINE:    cfg_next.goal_sine    = cfg_data[15:0];
                lfhc_pkg::REG_GOAL_COSINE:  cfg_next.goal_cosine  = cfg_data[15:0];
                lfhc_pkg::REG_MAX_LINEAR:   cfg_next.max_linear   = cfg_data[9:0];
                lfhc_pkg::REG_MAX_ANGULAR:  cfg_next.max_angular  = cfg_data[11:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= lfhc_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/lfhc_offset.sv
// lateral offset pipeline: position difference, products, threshold compare
module lfhc_offset (
    input  logic                clk,
    input  logic                rst_n,
    input  lfhc_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [23:0]  pos_x,
    input  logic signed [23:0]  pos_y,
    input  logic signed [15:0]  yaw,
    output logic                out_valid,
    input  logic                out_stall,
    output lfhc_pkg::offset_t   res
);

    typedef struct packed {
        logic                                no_goal;
        logic signed [lfhc_pkg::DIFF_W-1:0]  dx;
        logic signed [lfhc_pkg::DIFF_W-1:0]  dy;
        logic signed [15:0]                  yaw;
    } diff_t;

    typedef struct packed {
        logic                                    no_goal;
        logic signed [lfhc_pkg::OFF_PROD_W-1:0]  ps;
        logic signed [lfhc_pkg::OFF_PROD_W-1:0]  pc;
        logic signed [15:0]                      yaw;
    } prod_t;

    logic diff_valid_reg, diff_valid_next;
    logic prod_valid_reg, prod_valid_next;
    logic res_valid_reg, res_valid_next;
    logic diff_ld, prod_ld, res_ld;

    diff_t             diff_reg, diff_next;
    prod_t             prod_reg, prod_next;
    lfhc_pkg::offset_t res_reg, res_next;

    logic signed [lfhc_pkg::D_W-1:0] offset_sum;

    assign out_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        res_ld   = !res_valid_reg || !out_stall;
        prod_ld  = !prod_valid_reg || res_ld;
        diff_ld  = !diff_valid_reg || prod_ld;
        in_stall = !diff_ld;

        diff_valid_next = diff_ld ? in_valid : diff_valid_reg;
        prod_valid_next = prod_ld ? diff_valid_reg : prod_valid_reg;
        res_valid_next  = res_ld ? prod_valid_reg : res_valid_reg;

        diff_next.no_goal = !cfg.goal_set;
        diff_next.dx      = lfhc_pkg::DIFF_W'(pos_x) - lfhc_pkg::DIFF_W'(cfg.goal_x);
        diff_next.dy      = lfhc_pkg::DIFF_W'(pos_y) - lfhc_pkg::DIFF_W'(cfg.goal_y);
        diff_next.yaw     = yaw;

        prod_next.no_goal = diff_reg.no_goal;
        prod_next.ps      = lfhc_pkg::OFF_PROD_W'(cfg.goal_sine)
                            * lfhc_pkg::OFF_PROD_W'(diff_reg.dx);
        prod_next.pc      = lfhc_pkg::OFF_PROD_W'(cfg.goal_cosine)
                            * lfhc_pkg::OFF_PROD_W'(diff_reg.dy);
        prod_next.yaw     = diff_reg.yaw;

        offset_sum = lfhc_pkg::D_W'(prod_reg.pc) - lfhc_pkg::D_W'(prod_reg.ps);

        res_next.no_goal = prod_reg.no_goal;
        res_next.hi      = offset_sum > lfhc_pkg::OFF_HI;
        res_next.lo      = offset_sum < lfhc_pkg::OFF_LO;
        res_next.yaw     = prod_reg.yaw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            diff_valid_reg <= diff_valid_next;
            prod_valid_reg <= prod_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (diff_ld)
        begin
            diff_reg <= diff_next;
        end
        if (prod_ld)
        begin
            prod_reg <= prod_next;
        end
        if (res_ld)
        begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: rtl/lfhc_heading.sv
// target heading selection and wrapped heading error stage
module lfhc_heading (
    input  logic               clk,
    input  logic               rst_n,
    input  lfhc_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  lfhc_pkg::offset_t  src,
    output logic               out_valid,
    input  logic               out_stall,
    output lfhc_pkg::err_t     res
);

    logic valid_reg, valid_next;
    logic ld;

    lfhc_pkg::err_t res_reg, res_next;

    logic signed [lfhc_pkg::ANG_W-1:0] gh;
    logic signed [lfhc_pkg::ANG_W-1:0] cand;
    logic signed [lfhc_pkg::ANG_W-1:0] target;
    logic signed [lfhc_pkg::ANG_W-1:0] err;
    logic signed [lfhc_pkg::ANG_W-1:0] abs_err;

    assign out_valid = valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        ld         = !valid_reg || !out_stall;
        in_stall   = !ld;
        valid_next = ld ? in_valid : valid_reg;

        gh = lfhc_pkg::ANG_W'(cfg.goal_heading);
        if (src.hi)
        begin
            cand = gh - lfhc_pkg::QTR_A;
        end
        else if (src.lo)
        begin
            cand = gh + lfhc_pkg::QTR_A;
        end
        else
        begin
            cand = gh;
        end
        target  = lfhc_pkg::wrap_angle(cand);
        err     = lfhc_pkg::wrap_angle(target - lfhc_pkg::ANG_W'(src.yaw));
        abs_err = err[lfhc_pkg::ANG_W-1] ? -err : err;

        res_next.no_goal = src.no_goal;
        res_next.neg     = err[lfhc_pkg::ANG_W-1];
        res_next.sat     = abs_err >= lfhc_pkg::C1_A;
        res_next.err     = err;
        res_next.mag     = abs_err[lfhc_pkg::C1_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: rtl/lfhc_speed.sv
// speed scaling pipeline: scaled numerators, reciprocal divide, correction, output register
module lfhc_speed (
    input  logic               clk,
    input  logic               rst_n,
    input  lfhc_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  lfhc_pkg::err_t     src,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [9:0]         linear_speed,
    output logic signed [12:0] angular_speed,
    output logic signed [15:0] heading_error,
    output logic               no_goal
);

    typedef struct packed {
        logic                          no_goal;
        logic                          sat;
        logic                          neg;
        logic [15:0]                   err;
        logic [lfhc_pkg::N_W-1:0]      n_lin;
        logic [lfhc_pkg::N_W-1:0]      n_ang;
    } scale_t;

    typedef struct packed {
        logic                          no_goal;
        logic                          sat;
        logic                          neg;
        logic [15:0]                   err;
        logic [lfhc_pkg::N_W-1:0]      n_lin;
        logic [lfhc_pkg::N_W-1:0]      n_ang;
        logic [lfhc_pkg::Q_W-1:0]      q_lin;
        logic [lfhc_pkg::Q_W-1:0]      q_ang;
    } quot_t;

    logic scale_valid_reg, scale_valid_next;
    logic quot_valid_reg, quot_valid_next;
    logic out_valid_reg, out_valid_next;
    logic scale_ld, quot_ld, out_ld;

    scale_t scale_reg, scale_next;
    quot_t  quot_reg, quot_next;

    logic [9:0]         linear_speed_reg, linear_speed_next;
    logic signed [12:0] angular_speed_reg, angular_speed_next;
    logic signed [15:0] heading_error_reg, heading_error_next;
    logic               no_goal_reg, no_goal_next;

    logic [lfhc_pkg::C1_W-1:0]   x_lin;
    logic [lfhc_pkg::PROD_W-1:0] prod_lin;
    logic [lfhc_pkg::PROD_W-1:0] prod_ang;
    logic [lfhc_pkg::N_W-1:0]    rem_lin;
    logic [lfhc_pkg::N_W-1:0]    rem_ang;
    logic [lfhc_pkg::Q_W-1:0]    q_lin;
    logic [lfhc_pkg::Q_W-1:0]    q_ang;
    logic [11:0]                 ang_mag;
    logic signed [12:0]          ang_ext;

    assign out_valid     = out_valid_reg;
    assign linear_speed  = linear_speed_reg;
    assign angular_speed = angular_speed_reg;
    assign heading_error = heading_error_reg;
    assign no_goal       = no_goal_reg;

    always_comb
    begin
        out_ld   = !out_valid_reg || !out_stall;
        quot_ld  = !quot_valid_reg || out_ld;
        scale_ld = !scale_valid_reg || quot_ld;
        in_stall = !scale_ld;

        scale_valid_next = scale_ld ? in_valid : scale_valid_reg;
        quot_valid_next  = quot_ld ? scale_valid_reg : quot_valid_reg;
        out_valid_next   = out_ld ? quot_valid_reg : out_valid_reg;

        // numerators 2 v x + C1
        x_lin = src.sat ? '0 : lfhc_pkg::C1_W'(lfhc_pkg::C1_Q) - src.mag;
        scale_next.no_goal = src.no_goal;
        scale_next.sat     = src.sat;
        scale_next.neg     = src.neg;
        scale_next.err     = src.err[15:0];
        scale_next.n_lin   = ((lfhc_pkg::N_W'(cfg.max_linear) * lfhc_pkg::N_W'(x_lin)) << 1)
                             + lfhc_pkg::N_W'(lfhc_pkg::C1_Q);
        scale_next.n_ang   = ((lfhc_pkg::N_W'(cfg.max_angular) * lfhc_pkg::N_W'(src.mag)) << 1)
                             + lfhc_pkg::N_W'(lfhc_pkg::C1_Q);

        // quotient estimate, low by at most one
        prod_lin = lfhc_pkg::PROD_W'(scale_reg.n_lin) * lfhc_pkg::PROD_W'(lfhc_pkg::RECIP_M);
        prod_ang = lfhc_pkg::PROD_W'(scale_reg.n_ang) * lfhc_pkg::PROD_W'(lfhc_pkg::RECIP_M);
        quot_next.no_goal = scale_reg.no_goal;
        quot_next.sat     = scale_reg.sat;
        quot_next.neg     = scale_reg.neg;
        quot_next.err     = scale_reg.err;
        quot_next.n_lin   = scale_reg.n_lin;
        quot_next.n_ang   = scale_reg.n_ang;
        quot_next.q_lin   = prod_lin[lfhc_pkg::RECIP_K +: lfhc_pkg::Q_W];
        quot_next.q_ang   = prod_ang[lfhc_pkg::RECIP_K +: lfhc_pkg::Q_W];

        // remainder check and final selection
        rem_lin = quot_reg.n_lin - lfhc_pkg::N_W'(lfhc_pkg::N_W'(quot_reg.q_lin)
                  * lfhc_pkg::N_W'(lfhc_pkg::DIV_Q));
        rem_ang = quot_reg.n_ang - lfhc_pkg::N_W'(lfhc_pkg::N_W'(quot_reg.q_ang)
                  * lfhc_pkg::N_W'(lfhc_pkg::DIV_Q));
        q_lin = quot_reg.q_lin
                + lfhc_pkg::Q_W'(rem_lin >= lfhc_pkg::N_W'(lfhc_pkg::DIV_Q));
        q_ang = quot_reg.q_ang
                + lfhc_pkg::Q_W'(rem_ang >= lfhc_pkg::N_W'(lfhc_pkg::DIV_Q));

        ang_mag = quot_reg.sat ? cfg.max_angular : q_ang[11:0];
        ang_ext = 13'(ang_mag);

        if (quot_reg.no_goal)
        begin
            linear_speed_next  = '0;
            angular_speed_next = '0;
            heading_error_next = '0;
        end
        else
        begin
            linear_speed_next  = quot_reg.sat ? '0 : q_lin[9:0];
            angular_speed_next = quot_reg.neg ? -ang_ext : ang_ext;
            heading_error_next = quot_reg.err;
        end
        no_goal_next = quot_reg.no_goal;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_valid_reg <= 1'b0;
            quot_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            scale_valid_reg <= scale_valid_next;
            quot_valid_reg  <= quot_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scale_ld)
        begin
            scale_reg <= scale_next;
        end
        if (quot_ld)
        begin
            quot_reg <= quot_next;
        end
        if (out_ld)
        begin
            linear_speed_reg  <= linear_speed_next;
            angular_speed_reg <= angular_speed_next;
            heading_error_reg <= heading_error_next;
            no_goal_reg       <= no_goal_next;
        end
    end

endmodule

FILE: rtl/lfhc_checker.sv
// port level checks of the heading controller and their binding
`include "line_following_heading_controller_macros.svh"

module lfhc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [9:0]  linear_speed,
    input logic [12:0] angular_speed,
    input logic [15:0] heading_error,
    input logic        no_goal
);

    logic        motion_zero;
    logic        steer_valid;
    logic        err_zero;
    logic        err_neg;
    logic        turn_zero;
    logic        turn_not_left;
    logic        out_wait;
    logic [39:0] out_item;

    assign motion_zero   = linear_speed == 10'd0 && angular_speed == 13'd0
                           && heading_error == 16'd0;
    assign steer_valid   = out_valid && !no_goal;
    assign err_zero      = heading_error == 16'd0;
    assign err_neg       = heading_error[15];
    assign turn_zero     = angular_speed == 13'd0;
    assign turn_not_left = angular_speed[12] || turn_zero;
    assign out_wait      = out_valid && out_stall;
    assign out_item      = {linear_speed, angular_speed, heading_error, no_goal};

    // stopped output carries no motion
    `LFHC_ASSERT_SAME(a_no_goal_zero, out_valid && no_goal, motion_zero, "stopped result moves")

    // zero error gives no turn
    `LFHC_ASSERT_SAME(a_zero_err_no_turn, steer_valid && err_zero, turn_zero, "turn without error")

    // negative error turns right or not at all
    `LFHC_ASSERT_SAME(a_turn_sign, steer_valid && err_neg, turn_not_left, "wrong turn sign")

    // empty output stage never back-pressures the input
    `LFHC_ASSERT_SAME(a_in_free, !out_valid, !in_stall, "input stalled with empty output")

    // stalled result holds
    `LFHC_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_item), "result moved")

endmodule

bind line_following_heading_controller lfhc_checker u_lfhc_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the line following heading controller
module testbench;

    localparam int LATENCY     = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 238;

    typedef struct packed {
        logic [9:0]         linear;
        logic signed [12:0] angular;
        logic signed [15:0] err;
        logic               no_goal;
    } command_t;

    typedef struct {
        logic               is_write;
        lfhc_pkg::reg_idx_t idx;
        int                 value;
        int                 px;
        int                 py;
        int                 pyaw;
        logic               typed;
        command_t           want;
    } plan_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [23:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] yaw;
    logic               out_valid;
    logic               out_stall;
    logic [9:0]         linear_speed;
    logic signed [12:0] angular_speed;
    logic signed [15:0] heading_error;
    logic               no_goal;

    lfhc_pkg::cfg_t goal_regs;
    command_t       pending_cmds[$];
    plan_row_t      directed_plan[$];
    int             bad_results = 0;
    int             cycle_count = 0;
    int             stall_mode = 1;
    logic [15:0]    stall_pattern = 16'h0505;
    int             hold_requests = 0;
    int             hold_served = 0;

    line_following_heading_controller DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .yaw(yaw),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .linear_speed(linear_speed),
        .angular_speed(angular_speed),
        .heading_error(heading_error),
        .no_goal(no_goal)
    );

    always #5 clk = ~clk;

    function automatic longint fold_angle(longint v);
        longint r;
        r = v % (2 * lfhc_pkg::PI_Q);
        if (r < -lfhc_pkg::PI_Q)
        begin
            r = r + 2 * lfhc_pkg::PI_Q;
        end
        else if (r > lfhc_pkg::PI_Q)
        begin
            r = r - 2 * lfhc_pkg::PI_Q;
        end
        return r;
    endfunction

    function automatic command_t steer_command(logic signed [23:0] px, logic signed [23:0] py,
                                               logic signed [15:0] pyaw);
        longint   dx;
        longint   dy;
        longint   lateral;
        longint   gh;
        longint   target;
        longint   e;
        longint   ae;
        longint   lin;
        longint   ang;
        command_t c;
        c = '0;
        if (!goal_regs.goal_set)
        begin
            c.no_goal = 1'b1;
            return c;
        end
        dx = longint'(px) - longint'($signed(goal_regs.goal_x));
        dy = longint'(py) - longint'($signed(goal_regs.goal_y));
        lateral = -longint'($signed(goal_regs.goal_sine)) * dx
                  + longint'($signed(goal_regs.goal_cosine)) * dy;
        gh = longint'($signed(goal_regs.goal_heading));
        if (lateral > lfhc_pkg::OFFSET_LIMIT)
        begin
            target = fold_angle(gh - lfhc_pkg::QTR_Q);
        end
        else if (lateral < -lfhc_pkg::OFFSET_LIMIT)
        begin
            target = fold_angle(gh + lfhc_pkg::QTR_Q);
        end
        else
        begin
            target = fold_angle(gh);
        end
        e = fold_angle(target - longint'(pyaw));
        ae = (e < 0) ? -e : e;
        if (ae >= lfhc_pkg::C1_Q)
        begin
            lin = 0;
            ang = longint'(goal_regs.max_angular);
        end
        else
        begin
            lin = (longint'(goal_regs.max_linear) * (lfhc_pkg::C1_Q - ae) * 2 + lfhc_pkg::C1_Q)
                  / (2 * lfhc_pkg::C1_Q);
            ang = (longint'(goal_regs.max_angular) * ae * 2 + lfhc_pkg::C1_Q)
                  / (2 * lfhc_pkg::C1_Q);
        end
        if (e < 0)
        begin
            ang = -ang;
        end
        c.linear  = lin[9:0];
        c.angular = ang[12:0];
        c.err     = e[15:0];
        return c;
    endfunction

    function automatic plan_row_t reg_row(lfhc_pkg::reg_idx_t idx, int value);
        plan_row_t r;
        r.is_write = 1'b1;
        r.idx      = idx;
        r.value    = value;
        r.px       = 0;
        r.py       = 0;
        r.pyaw     = 0;
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic plan_row_t odo_row(int px, int py, int pyaw);
        plan_row_t r;
        r = reg_row(lfhc_pkg::REG_GOAL_SET, 0);
        r.is_write = 1'b0;
        r.px       = px;
        r.py       = py;
        r.pyaw     = pyaw;
        return r;
    endfunction

    function automatic plan_row_t odo_want(int px, int py, int pyaw,
                                           int lin, int ang, int err, logic ng);
        plan_row_t r;
        r = odo_row(px, py, pyaw);
        r.typed        = 1'b1;
        r.want.linear  = lin[9:0];
        r.want.angular = ang[12:0];
        r.want.err     = err[15:0];
        r.want.no_goal = ng;
        return r;
    endfunction

    task automatic write_reg(lfhc_pkg::reg_idx_t idx, int value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value[23:0];
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            lfhc_pkg::REG_GOAL_SET:     goal_regs.goal_set     = value[0];
            lfhc_pkg::REG_GOAL_X:       goal_regs.goal_x       = value[23:0];
            lfhc_pkg::REG_GOAL_Y:       goal_regs.goal_y       = value[23:0];
            lfhc_pkg::REG_GOAL_HEADING: goal_regs.goal_heading = value[15:0];
            lfhc_pkg::REG_GOAL_SINE:    goal_regs.goal_sine    = value[15:0];
            lfhc_pkg::REG_GOAL_COSINE:  goal_regs.goal_cosine  = value[15:0];
            lfhc_pkg::REG_MAX_LINEAR:   goal_regs.max_linear   = value[9:0];
            lfhc_pkg::REG_MAX_ANGULAR:  goal_regs.max_angular  = value[11:0];
            default:                    ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic push_odometry(int px, int py, int pyaw, logic typed, command_t want);
        command_t expected;
        @(negedge clk);
        in_valid = 1'b1;
        pos_x    = px[23:0];
        pos_y    = py[23:0];
        yaw      = pyaw[15:0];
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        expected = typed ? want : steer_command(pos_x, pos_y, yaw);
        pending_cmds.push_back(expected);
    endtask

    task automatic rest_sender(int cycles);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic load_goal(int phase);
        int  gs;
        int  gx;
        int  gy;
        int  heading;
        int  sine;
        int  cosine;
        int  mlin;
        int  mang;
        real ang;
        if (phase == 1)
        begin
            gs = 1;
            gx = -8388608;
            gy = 8388607;
            heading = lfhc_pkg::PI_Q;
            sine = 0;
            cosine = -16384;
            mlin = 1000;
            mang = 4000;
        end
        else if (phase == 5)
        begin
            gs = 1;
            gx = 8388607;
            gy = -8388608;
            heading = -lfhc_pkg::PI_Q;
            sine = 0;
            cosine = -16384;
            mlin = 0;
            mang = 0;
        end
        else
        begin
            gs = ($urandom_range(0, 7) != 0) ? 1 : 0;
            if ($urandom_range(0, 3) == 0)
            begin
                gx = $urandom();
                gy = $urandom();
            end
            else
            begin
                gx = int'($urandom_range(0, 200000)) - 100000;
                gy = int'($urandom_range(0, 200000)) - 100000;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                heading = int'($urandom_range(0, 65535)) - 32768;
            end
            else
            begin
                heading = int'($urandom_range(0, 2 * lfhc_pkg::PI_Q)) - lfhc_pkg::PI_Q;
            end
            if ($urandom_range(0, 4) == 0)
            begin
                sine   = int'($urandom_range(0, 65535)) - 32768;
                cosine = int'($urandom_range(0, 65535)) - 32768;
            end
            else
            begin
                ang    = heading / 8192.0;
                sine   = int'($sin(ang) * 16384.0);
                cosine = int'($cos(ang) * 16384.0);
            end
            mlin = $urandom_range(0, 1000);
            mang = $urandom_range(0, 4000);
        end
        write_reg(lfhc_pkg::REG_GOAL_X, gx);
        write_reg(lfhc_pkg::REG_GOAL_Y, gy);
        write_reg(lfhc_pkg::REG_GOAL_HEADING, heading);
        write_reg(lfhc_pkg::REG_GOAL_SINE, sine);
        write_reg(lfhc_pkg::REG_GOAL_COSINE, cosine);
        write_reg(lfhc_pkg::REG_MAX_LINEAR, mlin);
        write_reg(lfhc_pkg::REG_MAX_ANGULAR, mang);
        write_reg(lfhc_pkg::REG_GOAL_SET, gs);
    endtask

    task automatic random_odometry(output int px, output int py, output int pyaw);
        int pick;
        int lean;
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            px = $urandom();
            py = $urandom();
            if ($urandom_range(0, 9) == 0)
            begin
                pyaw = int'($urandom_range(0, 65535)) - 32768;
            end
            else
            begin
                pyaw = int'($urandom_range(0, 2 * lfhc_pkg::PI_Q)) - lfhc_pkg::PI_Q;
            end
        end
        else
        begin
            // near the goal line so the offset test and the speed ramps both get exercised
            px = int'($signed(goal_regs.goal_x)) + int'($urandom_range(0, 1600)) - 800;
            py = int'($signed(goal_regs.goal_y)) + int'($urandom_range(0, 1600)) - 800;
            case ($urandom_range(0, 2))
                0:       lean = -lfhc_pkg::QTR_Q;
                1:       lean = 0;
                default: lean = lfhc_pkg::QTR_Q;
            endcase
            pyaw = int'($signed(goal_regs.goal_heading)) + lean
                   + int'($urandom_range(0, 10000)) - 5000;
            if (pyaw > lfhc_pkg::PI_Q)
            begin
                pyaw = pyaw - 2 * lfhc_pkg::PI_Q;
            end
            else if (pyaw < -lfhc_pkg::PI_Q)
            begin
                pyaw = pyaw + 2 * lfhc_pkg::PI_Q;
            end
        end
    endtask

    // receiver side: stall modes plus one long hold-off
    initial
    begin
        int pat_pos;
        pat_pos = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served < hold_requests)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_served++;
            end
            case (stall_mode)
                0:       out_stall = 1'b0;
                1:       out_stall = ($urandom_range(0, 3) == 0);
                2:       out_stall = ($urandom_range(0, 9) < 6);
                default: out_stall = stall_pattern[pat_pos];
            endcase
            pat_pos = (pat_pos + 1) % 16;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        command_t got;
        command_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.linear  = linear_speed;
            got.angular = angular_speed;
            got.err     = heading_error;
            got.no_goal = no_goal;
            if (pending_cmds.size() == 0)
            begin
                bad_results++;
                if (bad_results <= 10)
                begin
                    $display("unexpected result: lin %0d ang %0d err %0d no_goal %0b",
                             got.linear, got.angular, got.err, got.no_goal);
                end
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (got.linear !== want.linear || got.angular !== want.angular
                    || got.err !== want.err || got.no_goal !== want.no_goal)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                    begin
                        $display("mismatch: expected lin %0d ang %0d err %0d no_goal %0b",
                                 want.linear, want.angular, want.err, want.no_goal);
                        $display("          got      lin %0d ang %0d err %0d no_goal %0b",
                                 got.linear, got.angular, got.err, got.no_goal);
                    end
                end
            end
        end
    end

    initial
    begin
        int phase;
        int n;
        int px;
        int py;
        int pyaw;
        int burst_left;
        int gap;
        int gap_max;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = lfhc_pkg::REG_GOAL_SET;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pos_x     = '0;
        pos_y     = '0;
        yaw       = '0;
        goal_regs.goal_set     = 1'b0;
        goal_regs.goal_x       = '0;
        goal_regs.goal_y       = '0;
        goal_regs.goal_heading = '0;
        goal_regs.goal_sine    = '0;
        goal_regs.goal_cosine  = 16'sd16384;
        goal_regs.max_linear   = 10'd300;
        goal_regs.max_angular  = 12'd1000;

        // stopped until a goal is set
        directed_plan.push_back(odo_want(8388607, -8388608, lfhc_pkg::PI_Q, 0, 0, 0, 1'b1));
        directed_plan.push_back(odo_want(-8388608, 8388607, -lfhc_pkg::PI_Q, 0, 0, 0, 1'b1));
        directed_plan.push_back(reg_row(lfhc_pkg::REG_GOAL_SET, 1));
        directed_plan.push_back(odo_want(0, 0, 0, 300, 0, 0, 1'b0));
        directed_plan.push_back(odo_want(0, 0, lfhc_pkg::C1_Q, 0, -1000, -lfhc_pkg::C1_Q, 1'b0));
        directed_plan.push_back(odo_want(0, 0, -lfhc_pkg::C1_Q, 0, 1000, lfhc_pkg::C1_Q, 1'b0));
        // offset just past and right at the band edge
        directed_plan.push_back(odo_want(0, 251, 0, 0, -1000, -lfhc_pkg::QTR_Q, 1'b0));
        directed_plan.push_back(odo_want(0, 250, 0, 300, 0, 0, 1'b0));
        directed_plan.push_back(odo_want(0, -251, 0, 0, 1000, lfhc_pkg::QTR_Q, 1'b0));
        directed_plan.push_back(odo_want(0, 0, lfhc_pkg::PI_Q, 0, -1000, -lfhc_pkg::PI_Q, 1'b0));
        directed_plan.push_back(odo_want(0, 0, -lfhc_pkg::PI_Q, 0, 1000, lfhc_pkg::PI_Q, 1'b0));
        // yaw outside plus or minus pi
        directed_plan.push_back(odo_row(0, 0, 32767));
        directed_plan.push_back(odo_row(0, 0, -32768));
        directed_plan.push_back(odo_row(0, 0, 100));
        directed_plan.push_back(reg_row(lfhc_pkg::REG_GOAL_HEADING, lfhc_pkg::PI_Q));
        directed_plan.push_back(reg_row(lfhc_pkg::REG_MAX_LINEAR, 1000));
        directed_plan.push_back(reg_row(lfhc_pkg::REG_MAX_ANGULAR, 4000));
        directed_plan.push_back(odo_row(0, -300, 0));
        directed_plan.push_back(odo_row(17, 300, 25000));
        // extreme goal point, inconsistent sine and cosine
        directed_plan.push_back(reg_row(lfhc_pkg::REG_GOAL_X, -8388608));
        directed_plan.push_back(reg_row(lfhc_pkg::REG_GOAL_Y, 8388607));
        directed_plan.push_back(reg_row(lfhc_pkg::REG_GOAL_SINE, -16384));
        directed_plan.push_back(reg_row(lfhc_pkg::REG_GOAL_COSINE, -32768));
        directed_plan.push_back(odo_row(8388607, -8388608, -lfhc_pkg::PI_Q));
        directed_plan.push_back(odo_row(-8388608, 8388607, 12345));
        directed_plan.push_back(reg_row(lfhc_pkg::REG_GOAL_HEADING, -32768));
        directed_plan.push_back(reg_row(lfhc_pkg::REG_GOAL_SINE, 32767));
        directed_plan.push_back(odo_row(1000, -1000, 0));
        directed_plan.push_back(reg_row(lfhc_pkg::REG_MAX_LINEAR, 0));
        directed_plan.push_back(reg_row(lfhc_pkg::REG_MAX_ANGULAR, 0));
        directed_plan.push_back(odo_row(0, 0, 200));
        directed_plan.push_back(reg_row(lfhc_pkg::REG_GOAL_SET, 0));
        directed_plan.push_back(odo_want(123, 456, 789, 0, 0, 0, 1'b1));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_write)
            begin
                rest_sender(1);
                wait_idle();
                write_reg(directed_plan[i].idx, directed_plan[i].value);
            end
            else
            begin
                push_odometry(directed_plan[i].px, directed_plan[i].py, directed_plan[i].pyaw,
                              directed_plan[i].typed, directed_plan[i].want);
            end
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            rest_sender(1);
            wait_idle();
            load_goal(phase);
            stall_mode    = phase % 4;
            stall_pattern = 16'($urandom()) & 16'h7777;
            gap_max       = (phase == 0 || phase == 3) ? 0 : $urandom_range(2, 12);
            if (phase == 3)
            begin
                hold_requests++;
            end
            burst_left = $urandom_range(1, 20);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                random_odometry(px, py, pyaw);
                push_odometry(px, py, pyaw, 1'b0, '0);
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
                    if (gap > 0)
                    begin
                        rest_sender(gap);
                    end
                end
            end
        end

        rest_sender(1);
        wait_idle();
        if (bad_results == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
